// ===== rtl/imdl_pkg.sv =====
// Shared types and constants for the indexed mesh display list parser.
// Result record layout, record kind codes, error codes, format codes, register map.
// No dependencies.
package imdl_pkg;

    localparam int ATTR_W = 5;

    localparam logic [2:0] KIND_PRIM  = 3'd0;
    localparam logic [2:0] KIND_VALUE = 3'd1;
    localparam logic [2:0] KIND_END   = 3'd2;
    localparam logic [2:0] KIND_USAGE = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_CMD    = 2'd1;
    localparam logic [1:0] ERR_DIRECT = 2'd2;

    localparam logic [1:0] FMT_NONE   = 2'd0;
    localparam logic [1:0] FMT_DIRECT = 2'd1;
    localparam logic [1:0] FMT_IDX8   = 2'd2;
    localparam logic [1:0] FMT_IDX16  = 2'd3;

    // Highest attribute number that may use direct format (matrix indexes)
    localparam int MTX_ATTR_LAST = 2;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;
    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_FORMATS = 2'd1;
    localparam logic [1:0] REG_LENGTH  = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [2:0]        kind;
        logic [3:0]        primitive_type;
        logic [2:0]        vertex_format;
        logic [15:0]       vertex_count;
        logic [15:0]       vertex_number;
        logic [ATTR_W-1:0] attribute;
        logic [15:0]       index_value;
        logic              all_ones_flag;
        logic [1:0]        error_code;
        logic              last;
    } result_t;

endpackage

// ===== rtl/indexed_mesh_display_list_parser.sv =====
// Top level of the indexed mesh display list parser: configuration registers and wiring.
// Depends on imdl_pkg, imdl_front, imdl_fifo, imdl_back.
//
//   channel  | handshake             | payload
//   input    | in_valid / in_ready   | data_byte, list_start
//   output   | out_valid / out_ready | kind ... last (one result record per beat)
//   config   | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
// A byte is parsed in the cycle it is accepted, so bytes go in at one per cycle
// while the queue has room and no end, usage or error record is pending. A byte
// that ends the list is followed by the list end record and a walk of the usage
// store up to the highest used attribute (at most NUM_ATTRIBUTES); a direct-format
// error after a value or a primitive start adds an error record. Records go through
// the queue and the output register. The parser pushes one record per cycle, while
// there is room, into a QDEPTH-entry queue; output stalls back up into that queue.
// Reset clears all parse state and registers; no clearing pass is needed.
module indexed_mesh_display_list_parser #(
    parameter int NUM_ATTRIBUTES = 21
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           list_start,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     kind,
    output logic [3:0]                     primitive_type,
    output logic [2:0]                     vertex_format,
    output logic [15:0]                    vertex_count,
    output logic [15:0]                    vertex_number,
    output logic [imdl_pkg::ATTR_W-1:0]    attribute,
    output logic [15:0]                    index_value,
    output logic                           all_ones_flag,
    output logic [1:0]                     error_code,
    output logic                           last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [imdl_pkg::PADDR_W-1:0]   paddr,
    input  logic [imdl_pkg::PDATA_W-1:0]   pwdata,
    output logic [imdl_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import imdl_pkg::*;

    localparam int N = NUM_ATTRIBUTES;

    logic [N-1:0]   enable_reg;
    logic [2*N-1:0] formats_reg;
    logic [31:0]    length_reg;
    logic [1:0]     reg_idx;
    logic           q_push, q_full, q_pop, q_valid;
    result_t        push_data, q_data, out_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= '0;
            formats_reg <= '0;
            length_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_ENABLE:  enable_reg  <= pwdata[N-1:0];
                REG_FORMATS: formats_reg <= pwdata[2*N-1:0];
                REG_LENGTH:  length_reg  <= pwdata[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ENABLE:  prdata = PDATA_W'(enable_reg);
            REG_FORMATS: prdata = PDATA_W'(formats_reg);
            REG_LENGTH:  prdata = PDATA_W'(length_reg);
            default:     prdata = '0;
        endcase
    end

    imdl_front #(
        .NUM_ATTRIBUTES (NUM_ATTRIBUTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .list_start   (list_start),
        .attr_enable  (enable_reg),
        .attr_formats (formats_reg),
        .list_length  (length_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (push_data)
    );

    imdl_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (push_data),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_data)
    );

    imdl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind           = out_data.kind;
    assign primitive_type = out_data.primitive_type;
    assign vertex_format  = out_data.vertex_format;
    assign vertex_count   = out_data.vertex_count;
    assign vertex_number  = out_data.vertex_number;
    assign attribute      = out_data.attribute;
    assign index_value    = out_data.index_value;
    assign all_ones_flag  = out_data.all_ones_flag;
    assign error_code     = out_data.error_code;
    assign last           = out_data.last;

endmodule

// ===== rtl/imdl_front.sv =====
// Front end: accepts display list bytes, parses commands and indexes, keeps usage maxima.
// Pushes result records into the queue; one record per cycle while the queue has room.
// Depends on imdl_pkg.
module imdl_front #(
    parameter int NUM_ATTRIBUTES = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          list_start,
    input  logic [NUM_ATTRIBUTES-1:0]     attr_enable,
    input  logic [2*NUM_ATTRIBUTES-1:0]   attr_formats,
    input  logic [31:0]                   list_length,
    input  logic                          q_full,
    output logic                          q_push,
    output imdl_pkg::result_t             q_data
);
    import imdl_pkg::*;

    localparam int N  = NUM_ATTRIBUTES;
    localparam int AW = (N > 1) ? $clog2(N) : 1;
    localparam int PW = $clog2(N + 1);

    typedef enum logic [2:0] {
        PH_CMD, PH_CNT_HI, PH_CNT_LO, PH_IDX, PH_IDX_LO, PH_DONE, PH_HALT
    } phase_t;

    typedef enum logic [1:0] {F_RUN, F_ERR, F_END, F_DUMP} fsm_t;

    function automatic logic [AW:0] lowest(input logic [N-1:0] m);
        logic [AW:0] r;
        r = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (m[i])
                r = {1'b1, AW'(i)};
        end
        return r;
    endfunction

    fsm_t          fsm_reg, fsm_next;
    phase_t        phase_reg, phase_next;
    logic [31:0]   bc_reg, bc_next;
    logic [15:0]   vr_reg, vr_next;
    logic [15:0]   cv_reg, cv_next;
    logic [AW-1:0] ca_reg, ca_next;
    logic [7:0]    hold_reg, hold_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [N-1:0]  seen_reg, seen_next;
    logic [N-1:0]  val_reg, val_next;
    logic [AW-1:0] dump_reg, dump_next;
    result_t       errb_reg, errb_next;
    logic [15:0]   umax_mem [N];

    phase_t        e_phase;
    logic [31:0]   e_bc;
    logic [15:0]   e_vr, e_cv;
    logic [AW-1:0] e_ca;
    logic [7:0]    e_hold, e_cmd;
    logic [N-1:0]  e_seen;
    logic [N-1:0]  e_val;

    logic [N-1:0]  cand, zm;
    logic          accept;
    logic [31:0]   bc_inc;
    logic [15:0]   cnt;
    logic [1:0]    fmt_cur;
    logic [AW-1:0] rd_addr;
    logic [15:0]   umax_rd;
    logic          have_a, have_b, go_end, sk_use, rec_do, rec_we;
    logic [15:0]   rec_val;
    result_t       rec_a;

    logic [PW-1:0] sk_p;
    logic [15:0]   sk_cv, sk_vr, vr1, cv1;
    logic [N-1:0]  geq, lt1, lt2, sk_mark;
    logic [AW:0]   l1, l2;
    logic          sk_hit, sk_err;
    logic [AW-1:0] sk_a;
    logic [15:0]   sk_cvo, sk_vro;
    logic [N-1:0]  hi_mask;
    logic          seen_d, last_u;

    // Effective state: list_start drops the previous list
    always_comb
    begin
        e_phase = list_start ? PH_CMD : phase_reg;
        e_bc    = list_start ? '0 : bc_reg;
        e_vr    = list_start ? '0 : vr_reg;
        e_cv    = list_start ? '0 : cv_reg;
        e_ca    = list_start ? '0 : ca_reg;
        e_hold  = list_start ? '0 : hold_reg;
        e_cmd   = list_start ? '0 : cmd_reg;
        e_seen  = list_start ? '0 : seen_reg;
        e_val   = list_start ? '0 : val_reg;
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            cand[i] = attr_enable[i] && (attr_formats[2*i +: 2] != FMT_NONE);
            zm[i]   = attr_enable[i] && (attr_formats[2*i +: 2] == FMT_NONE);
        end
    end

    assign accept  = (fsm_reg == F_RUN) && in_valid && !q_full;
    assign in_ready = (fsm_reg == F_RUN) && !q_full;
    assign bc_inc  = (e_bc == 32'hffff_ffff) ? e_bc : e_bc + 32'd1;
    assign cnt     = {e_hold, data_byte};
    assign fmt_cur = attr_formats[2*e_ca +: 2];
    assign rd_addr = (fsm_reg == F_DUMP) ? dump_reg : e_ca;
    assign umax_rd = umax_mem[rd_addr];

    // Next attribute that reads a byte, wrapping to the next vertex at most once;
    // attributes with format none that are skipped count as used.
    assign sk_p  = (e_phase == PH_CNT_LO) ? '0 : PW'(e_ca) + PW'(1);
    assign sk_cv = (e_phase == PH_CNT_LO) ? '0 : e_cv;
    assign sk_vr = (e_phase == PH_CNT_LO) ? cnt : e_vr;
    assign vr1   = sk_vr - 16'd1;
    assign cv1   = sk_cv + 16'd1;
    assign l1    = lowest(cand & geq);
    assign l2    = lowest(cand);

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            geq[i] = (i >= int'(sk_p));
            lt1[i] = (i < int'(l1[AW-1:0]));
            lt2[i] = (i < int'(l2[AW-1:0]));
        end
        if (l1[AW])
        begin
            sk_hit = 1'b1; sk_a = l1[AW-1:0]; sk_cvo = sk_cv; sk_vro = sk_vr;
            sk_mark = zm & geq & lt1;
        end
        else if (vr1 == 16'd0)
        begin
            sk_hit = 1'b0; sk_a = '0; sk_cvo = cv1; sk_vro = '0;
            sk_mark = zm & geq;
        end
        else if (l2[AW])
        begin
            sk_hit = 1'b1; sk_a = l2[AW-1:0]; sk_cvo = cv1; sk_vro = vr1;
            sk_mark = (zm & geq) | (zm & lt2);
        end
        else
        begin
            sk_hit = 1'b0; sk_a = '0; sk_cvo = cv1 + vr1; sk_vro = '0;
            sk_mark = zm;
        end
        sk_err = sk_hit && (attr_formats[2*sk_a +: 2] == FMT_DIRECT)
                 && (int'(sk_a) > MTX_ATTR_LAST);
    end

    // Byte parse
    always_comb
    begin
        phase_next = e_phase;
        bc_next    = e_bc;
        vr_next    = e_vr;
        cv_next    = e_cv;
        ca_next    = e_ca;
        hold_next  = e_hold;
        cmd_next   = e_cmd;
        seen_next  = e_seen;
        val_next   = e_val;
        errb_next  = errb_reg;
        have_a     = 1'b0;
        have_b     = 1'b0;
        go_end     = 1'b0;
        sk_use     = 1'b0;
        rec_do     = 1'b0;
        rec_val    = '0;
        rec_a      = '0;
        case (e_phase)
            PH_CMD:
            begin
                if (e_bc >= list_length)
                    go_end = 1'b1;
                else
                begin
                    bc_next = bc_inc;
                    if (data_byte == 8'h00)
                        go_end = 1'b1;
                    else if (!data_byte[7])
                    begin
                        have_a           = 1'b1;
                        rec_a.kind       = KIND_ERROR;
                        rec_a.error_code = ERR_CMD;
                        phase_next       = PH_HALT;
                    end
                    else
                    begin
                        cmd_next   = data_byte;
                        phase_next = PH_CNT_HI;
                    end
                end
            end
            PH_CNT_HI:
            begin
                bc_next    = bc_inc;
                hold_next  = data_byte;
                phase_next = PH_CNT_LO;
            end
            PH_CNT_LO:
            begin
                bc_next              = bc_inc;
                have_a               = 1'b1;
                rec_a.kind           = KIND_PRIM;
                rec_a.primitive_type = e_cmd[6:3];
                rec_a.vertex_format  = e_cmd[2:0];
                rec_a.vertex_count   = cnt;
                cv_next    = '0;
                ca_next    = '0;
                vr_next    = cnt;
                phase_next = PH_CMD;
                if (cnt != 16'd0)
                begin
                    if (cand == '0)
                    begin
                        seen_next = e_seen | zm;
                        vr_next   = '0;
                    end
                    else
                        sk_use = 1'b1;
                end
            end
            PH_IDX:
            begin
                bc_next = bc_inc;
                if (fmt_cur == FMT_IDX16)
                begin
                    hold_next  = data_byte;
                    phase_next = PH_IDX_LO;
                end
                else
                begin
                    rec_do  = 1'b1;
                    rec_val = {8'h00, data_byte};
                    sk_use  = 1'b1;
                end
            end
            PH_IDX_LO:
            begin
                bc_next = bc_inc;
                rec_do  = 1'b1;
                rec_val = {e_hold, data_byte};
                sk_use  = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (rec_do)
        begin
            have_a              = 1'b1;
            rec_a.kind          = KIND_VALUE;
            rec_a.vertex_number = e_cv;
            rec_a.attribute     = ATTR_W'(e_ca);
            rec_a.index_value   = rec_val;
            rec_a.all_ones_flag = (e_phase == PH_IDX_LO) ? (rec_val == 16'hffff)
                                                         : (rec_val == 16'h00ff);
            seen_next[e_ca]     = 1'b1;
            val_next[e_ca]      = 1'b1;
        end

        if (sk_use)
        begin
            seen_next = seen_next | sk_mark;
            ca_next   = sk_a;
            cv_next   = sk_cvo;
            vr_next   = sk_vro;
            if (!sk_hit)
                phase_next = PH_CMD;
            else if (sk_err)
            begin
                phase_next               = PH_HALT;
                have_b                   = 1'b1;
                errb_next                = '0;
                errb_next.kind           = KIND_ERROR;
                errb_next.vertex_number  = sk_cvo;
                errb_next.attribute      = ATTR_W'(sk_a);
                errb_next.error_code     = ERR_DIRECT;
                errb_next.last           = 1'b1;
            end
            else
                phase_next = PH_IDX;
        end

        // Length is checked only once a primitive has completed
        if (phase_next == PH_CMD && bc_next >= list_length && have_a)
            go_end = 1'b1;
        if (go_end)
            phase_next = PH_DONE;
        rec_a.last = !(have_b || go_end);
    end

    assign rec_we = rec_do && (!e_val[e_ca] || (umax_rd <= rec_val));

    // Result sequencing
    always_comb
    begin
        for (int i = 0; i < N; i++)
            hi_mask[i] = (i > int'(dump_reg));
        seen_d    = seen_reg[dump_reg];
        last_u    = ((seen_reg & hi_mask) == '0);
        fsm_next  = fsm_reg;
        dump_next = dump_reg;
        q_push    = 1'b0;
        q_data    = '0;
        case (fsm_reg)
            F_RUN:
            begin
                q_push = accept && have_a;
                q_data = rec_a;
                if (accept)
                begin
                    if (have_b)
                        fsm_next = F_ERR;
                    else if (go_end)
                        fsm_next = F_END;
                end
            end
            F_ERR:
            begin
                q_push = !q_full;
                q_data = errb_reg;
                if (!q_full)
                    fsm_next = F_RUN;
            end
            F_END:
            begin
                q_push      = !q_full;
                q_data.kind = KIND_END;
                q_data.last = (seen_reg == '0);
                dump_next   = '0;
                if (!q_full)
                    fsm_next = (seen_reg == '0) ? F_RUN : F_DUMP;
            end
            F_DUMP:
            begin
                q_push            = seen_d && !q_full;
                q_data.kind       = KIND_USAGE;
                q_data.attribute  = ATTR_W'(dump_reg);
                // used only through format none: the maximum is still zero
                q_data.index_value = val_reg[dump_reg] ? umax_rd : 16'd0;
                q_data.last       = last_u;
                if (!seen_d || !q_full)
                begin
                    if (seen_d && last_u)
                        fsm_next = F_RUN;
                    else
                        dump_next = dump_reg + AW'(1);
                end
            end
            default:
            begin
                fsm_next = F_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg   <= F_RUN;
            phase_reg <= PH_CMD;
            bc_reg    <= '0;
            vr_reg    <= '0;
            cv_reg    <= '0;
            ca_reg    <= '0;
            hold_reg  <= '0;
            cmd_reg   <= '0;
            seen_reg  <= '0;
            val_reg   <= '0;
            dump_reg  <= '0;
            errb_reg  <= '0;
        end
        else
        begin
            fsm_reg  <= fsm_next;
            dump_reg <= dump_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                bc_reg    <= bc_next;
                vr_reg    <= vr_next;
                cv_reg    <= cv_next;
                ca_reg    <= ca_next;
                hold_reg  <= hold_next;
                cmd_reg   <= cmd_next;
                seen_reg  <= seen_next;
                val_reg   <= val_next;
                errb_reg  <= errb_next;
            end
        end
    end

    // Usage maxima; entries not marked in val_reg are never read out
    always_ff @(posedge clk)
    begin
        if (accept && rec_we)
            umax_mem[e_ca] <= rec_val;
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed into a full queue");

    a_attr_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ca_reg) < N)
        else $error("current attribute out of range");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_data.last) |=> !(in_valid && in_ready))
        else $error("byte accepted before its results were all queued");

endmodule

// ===== rtl/imdl_fifo.sv =====
// Result queue between the parser front end and the output stage.
// Small register-based FIFO of result records.
// Depends on imdl_pkg.
module imdl_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  imdl_pkg::result_t wdata,
    output logic              full,
    input  logic              pop,
    output logic              rvalid,
    output imdl_pkg::result_t rdata
);
    import imdl_pkg::*;

    result_t            mem [QDEPTH];
    logic [QPTR_W-1:0]  wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;

    assign full   = (cnt_reg == QCNT_W'(QDEPTH));
    assign rvalid = (cnt_reg != '0);
    assign rdata  = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + QPTR_W'(1);
            if (pop)
                rptr_reg <= rptr_reg + QPTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rvalid)
        else $error("queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) <= QDEPTH)
        else $error("queue count beyond depth");

endmodule

// ===== rtl/imdl_back.sv =====
// Output stage: drains queue into output register, one beat per cycle unless stalled.
// Depends on imdl_pkg.
module imdl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  imdl_pkg::result_t q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output imdl_pkg::result_t out_data
);
    import imdl_pkg::*;

    logic    vld_reg;
    result_t data_reg;

    // Advance when the output register is empty or its beat is taken
    assign q_pop     = q_valid && (!vld_reg || out_ready);
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (!vld_reg || out_ready)
            vld_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_data;
    end

endmodule
